FILE: rtl/core/ncs_pkg.sv
package ncs_pkg;

   localparam int MAX_CENTERS    = 16;
   localparam int MAX_DIMENSIONS = 256;
   localparam int CIDX_W = $clog2(MAX_CENTERS);
   localparam int FIDX_W = $clog2(MAX_DIMENSIONS);
   localparam int ADDR_W = CIDX_W + FIDX_W;
   localparam int VAL_W  = 16;
   localparam int NORM_W = 40;
   localparam int DOT_W  = 40;
   localparam int DIST_W = 49;
   localparam int OUT_W  = 47;
   localparam int ACN_W  = 5;
   localparam int ADIM_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   localparam logic [1:0] KIND_CENTER_WR = 2'd0;
   localparam logic [1:0] KIND_POINT     = 2'd1;
   localparam logic [1:0] KIND_CLEAR     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_CENTERS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_DIMENSIONS = 2'd1;

   typedef struct packed {
      logic              load;
      logic              clear_we;
      logic              clear_norms;
      logic              cen_rd;
      logic              cen_wr;
      logic              pt_rd;
      logic              pt_wr;
      logic              walk;
      logic              emit;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic              pt_last;
      logic              pipe_busy;
      logic [CIDX_W-1:0] ncen_m1;
   } status_type;

endpackage

FILE: rtl/core/nearest_center_search_core.sv
// Nearest cluster center search (k-means assignment).
// Request channel: req_* fields are taken at a rising edge with start high and busy low.
// Kind 0 writes one center feature, kind 1 loads one point element,
// kind 2 clears the center store, kind 3 is dropped.
// A point element with last set then walks every active center over all 256
// positions, one center-store read per cycle, bound by the single center-store
// read port; the block stays busy and takes no new request until the result
// beat is emitted.
// The result beat (best center, distance, saturation flag) is on rsp_* for
// one cycle with rsp_strobe high; the receiver cannot stall, so it must take it.
// Configuration: csr_we with csr_index/csr_data; the user must write only while idle,
// the block does not enforce it. Reset runs a clearing pass over the center store
// with busy high; registers return to 16 centers and 256 dimensions.
module nearest_center_search_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [ncs_pkg::CIDX_W-1:0]    req_center_index,
   input  logic [ncs_pkg::FIDX_W-1:0]    req_feature_index,
   input  logic signed [ncs_pkg::VAL_W-1:0] req_feature_value,
   input  logic                          req_last,
   input  logic                          csr_we,
   input  logic [ncs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ncs_pkg::CSR_DAT_W-1:0] csr_data,
   output logic                          rsp_strobe,
   output logic [ncs_pkg::CIDX_W-1:0]    rsp_best_center,
   output logic [ncs_pkg::OUT_W-1:0]     rsp_min_sq_distance,
   output logic                          rsp_saturated
);
   import ncs_pkg::*;

   cmd_type    cmd;
   status_type status;

   ncs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   ncs_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_center_index    (req_center_index),
      .req_feature_index   (req_feature_index),
      .req_feature_value   (req_feature_value),
      .req_last            (req_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_best_center     (rsp_best_center),
      .rsp_min_sq_distance (rsp_min_sq_distance),
      .rsp_saturated       (rsp_saturated)
   );

endmodule

FILE: rtl/core/ncs_ctrl.sv
module ncs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_kind,
   output logic               busy,
   output ncs_pkg::cmd_type   cmd,
   input  ncs_pkg::status_type status
);
   import ncs_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CW_RD = 4'd2;
   localparam logic [3:0] S_CW_WR = 4'd3;
   localparam logic [3:0] S_PW_RD = 4'd4;
   localparam logic [3:0] S_PW_WR = 4'd5;
   localparam logic [3:0] S_WALK  = 4'd6;
   localparam logic [3:0] S_DRAIN = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] walk_end;

   assign walk_end = {status.ncen_m1, {FIDX_W{1'b1}}};
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.addr = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               case (req_kind)
                  KIND_CENTER_WR: state_in = S_CW_RD;
                  KIND_POINT:     state_in = S_PW_RD;
                  KIND_CLEAR: begin
                     cmd.clear_norms = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_CW_RD: begin
            cmd.cen_rd = 1'b1;
            state_in = S_CW_WR;
         end
         S_CW_WR: begin
            cmd.cen_wr = 1'b1;
            state_in = S_IDLE;
         end
         S_PW_RD: begin
            cmd.pt_rd = 1'b1;
            state_in = S_PW_WR;
         end
         S_PW_WR: begin
            cmd.pt_wr = 1'b1;
            state_in = status.pt_last ? S_WALK : S_IDLE;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == walk_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/ncs_datapath.sv
module ncs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ncs_pkg::cmd_type              cmd,
   output ncs_pkg::status_type           status,
   input  logic [1:0]                    req_kind,
   input  logic [ncs_pkg::CIDX_W-1:0]    req_center_index,
   input  logic [ncs_pkg::FIDX_W-1:0]    req_feature_index,
   input  logic signed [ncs_pkg::VAL_W-1:0] req_feature_value,
   input  logic                          req_last,
   input  logic                          csr_we,
   input  logic [ncs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ncs_pkg::CSR_DAT_W-1:0] csr_data,
   output logic                          rsp_strobe,
   output logic [ncs_pkg::CIDX_W-1:0]    rsp_best_center,
   output logic [ncs_pkg::OUT_W-1:0]     rsp_min_sq_distance,
   output logic                          rsp_saturated
);
   import ncs_pkg::*;

   localparam logic [DIST_W-1:0] DIST_MAX = {{(DIST_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};

   // configuration
   logic [ACN_W-1:0]  acn_ff;
   logic [ADIM_W-1:0] adim_ff;
   logic [ACN_W-1:0]  ncen;
   logic [ADIM_W-1:0] ndim;

   always_ff @(posedge clock) begin
      if (reset) begin
         acn_ff  <= ACN_W'(MAX_CENTERS);
         adim_ff <= ADIM_W'(MAX_DIMENSIONS);
      end else if (csr_we) begin
         if (csr_index == REG_ACTIVE_CENTERS) begin
            acn_ff <= csr_data[ACN_W-1:0];
         end
         if (csr_index == REG_ACTIVE_DIMENSIONS) begin
            adim_ff <= csr_data[ADIM_W-1:0];
         end
      end
   end

   always_comb begin
      ncen = acn_ff;
      if (acn_ff == '0) ncen = ACN_W'(1);
      if (acn_ff > ACN_W'(MAX_CENTERS)) ncen = ACN_W'(MAX_CENTERS);
      ndim = adim_ff;
      if (adim_ff == '0) ndim = ADIM_W'(1);
      if (adim_ff > ADIM_W'(MAX_DIMENSIONS)) ndim = ADIM_W'(MAX_DIMENSIONS);
   end

   // latched request beat
   logic [CIDX_W-1:0]       cidx_ff;
   logic [FIDX_W-1:0]       fidx_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    last_ff;
   logic                    ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cidx_ff <= req_center_index;
         fidx_ff <= req_feature_index;
         val_ff  <= req_feature_value;
         last_ff <= req_last && (req_kind == KIND_POINT);
         ok_ff   <= {1'b0, req_feature_index} < ndim;
      end
   end

   // memories
   logic signed [VAL_W-1:0] cen_mem [MAX_CENTERS*MAX_DIMENSIONS];
   logic signed [VAL_W-1:0] pt_mem  [MAX_DIMENSIONS];
   logic [MAX_DIMENSIONS-1:0] ptv_ff;
   logic signed [VAL_W-1:0] cen_q_ff, pt_q_ff;
   logic                    ptv_q_ff;
   logic [ADDR_W-1:0]       cen_raddr;
   logic [FIDX_W-1:0]       pt_raddr;

   assign cen_raddr = cmd.walk ? cmd.addr : {cidx_ff, fidx_ff};
   assign pt_raddr  = cmd.walk ? cmd.addr[FIDX_W-1:0] : fidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_we) begin
         cen_mem[cmd.addr] <= '0;
      end else if (cmd.cen_wr && ok_ff) begin
         cen_mem[{cidx_ff, fidx_ff}] <= val_ff;
      end
      cen_q_ff <= cen_mem[cen_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.pt_wr && ok_ff) begin
         pt_mem[fidx_ff] <= val_ff;
      end
      pt_q_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         ptv_ff <= '0;
      end else if (cmd.pt_wr && ok_ff) begin
         ptv_ff[fidx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ptv_q_ff <= ptv_ff[pt_raddr];
   end

   // norm maintenance
   logic [NORM_W-1:0]       cn_ff [MAX_CENTERS];
   logic [NORM_W-1:0]       pn_ff;
   logic signed [VAL_W-1:0] old_val;
   logic signed [2*VAL_W-1:0] sq_old, sq_new;

   assign old_val = cmd.pt_wr ? (ptv_q_ff ? pt_q_ff : '0) : cen_q_ff;
   assign sq_old  = old_val * old_val;
   assign sq_new  = val_ff * val_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_norms) begin
         for (int i = 0; i < MAX_CENTERS; i++) begin
            cn_ff[i] <= '0;
         end
      end else if (cmd.cen_wr && ok_ff) begin
         cn_ff[cidx_ff] <= cn_ff[cidx_ff]
                           - NORM_W'($unsigned(sq_old)) + NORM_W'($unsigned(sq_new));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         pn_ff <= '0;
      end else if (cmd.pt_wr && ok_ff) begin
         pn_ff <= pn_ff - NORM_W'($unsigned(sq_old)) + NORM_W'($unsigned(sq_new));
      end
   end

   // walk pipeline: read, multiply, accumulate, distance/compare
   logic                      s1_v_ff, s2_v_ff, s3_v_ff;
   logic [ADDR_W-1:0]         s1_a_ff, s2_a_ff;
   logic [CIDX_W-1:0]         s3_c_ff;
   logic signed [2*VAL_W-1:0] prod_ff;
   logic signed [DOT_W-1:0]   acc_ff, acc_in, dot_ff;
   logic signed [VAL_W-1:0]   pt_eff;
   logic signed [DIST_W-1:0]  dist_raw;
   logic [DIST_W-1:0]         dist_c;
   logic [DIST_W-1:0]         best_d_ff;
   logic [CIDX_W-1:0]         best_c_ff;

   assign pt_eff = ptv_q_ff ? pt_q_ff : '0;
   assign acc_in = (s2_a_ff[FIDX_W-1:0] == '0 ? DOT_W'(0) : acc_ff) + DOT_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.walk;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && (s2_a_ff[FIDX_W-1:0] == {FIDX_W{1'b1}});
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff <= cmd.addr;
      s2_a_ff <= s1_a_ff;
      prod_ff <= cen_q_ff * pt_eff;
      if (s2_v_ff) begin
         acc_ff  <= acc_in;
         dot_ff  <= acc_in;
         s3_c_ff <= s2_a_ff[ADDR_W-1:FIDX_W];
      end
   end

   always_comb begin
      dist_raw = $signed({{(DIST_W-NORM_W){1'b0}}, pn_ff})
               + $signed({{(DIST_W-NORM_W){1'b0}}, cn_ff[s3_c_ff]})
               - (DIST_W'(dot_ff) <<< 1);
      dist_c = dist_raw[DIST_W-1] ? '0 : $unsigned(dist_raw);
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff && (s3_c_ff == '0 || dist_c < best_d_ff)) begin
         best_d_ff <= dist_c;
         best_c_ff <= s3_c_ff;
      end
   end

   // result beat
   logic                rsp_strobe_ff;
   logic [CIDX_W-1:0]   rsp_c_ff;
   logic [OUT_W-1:0]    rsp_d_ff;
   logic                rsp_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_c_ff <= best_c_ff;
         rsp_s_ff <= best_d_ff > DIST_MAX;
         rsp_d_ff <= (best_d_ff > DIST_MAX) ? DIST_MAX[OUT_W-1:0] : best_d_ff[OUT_W-1:0];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_best_center     = rsp_c_ff;
   assign rsp_min_sq_distance = rsp_d_ff;
   assign rsp_saturated       = rsp_s_ff;

   assign status.pt_last   = last_ff;
   assign status.pipe_busy = s1_v_ff | s2_v_ff | s3_v_ff;
   assign status.ncen_m1   = CIDX_W'(ncen - 1'b1);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held two cycles");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(s1_v_ff || s2_v_ff || s3_v_ff))
      else $error("emit with walk pipeline busy");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> !(cmd.cen_wr || cmd.pt_wr || cmd.clear_we))
      else $error("store written during walk");

endmodule
